/* rtl/core/osdvls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdvls_pkg
// Types and constants shared by the video line scheduler files.
// ----------------------------------------------------------------------------
package osdvls_pkg;

  localparam int unsigned LINE_W   = 16;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned BAND_W   = 8;
  localparam int unsigned ROW_W    = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned ROW_SLOTS  = 4;

  localparam logic [LINE_W-1:0] VSYNC_CLEAR_ABOVE = 16'd200;

  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRAPHICS = 2'd2;

  localparam logic [EVENT_W-1:0] EVENT_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] EVENT_FRAME = 2'd1;
  localparam logic [EVENT_W-1:0] EVENT_ROW   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_START_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_START_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_START_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_START_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_LINE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_BAND       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAPHICS_START  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GFX_HEIGHT      = 3'd7;

  typedef struct packed {
    logic is_hsync;
  } osdvls_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]  draw_kind;
    logic [ROW_W-1:0]   draw_row;
    logic [LINE_W-1:0]  line_number;
    logic [EVENT_W-1:0] update_event;
  } osdvls_out_t;

  typedef struct packed {
    logic [ROW_SLOTS-1:0][POS_W-1:0] row_start;
    logic [POS_W-1:0]                end_line;
    logic [BAND_W-1:0]               text_band_height;
    logic [POS_W-1:0]                graphics_start;
    logic [POS_W-1:0]                gfx_height;
  } osdvls_cfg_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_count;
    logic [KIND_W-1:0] next_kind;
    logic [ROW_W-1:0]  active_row;
  } osdvls_state_t;

endpackage

/* rtl/core/osdvls_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdvls_stream_if
// Valid/ready channel carrying one request payload of type T.
// ----------------------------------------------------------------------------
interface osdvls_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/osdvls_line_decide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdvls_line_decide
// Per-pulse draw report, line counter advance or vertical clear, and next line type decision.
// ----------------------------------------------------------------------------
module osdvls_line_decide #(
  parameter int unsigned NUM_TEXT_ROWS = 4
) (
  input  osdvls_pkg::osdvls_cfg_t   cfg_i,
  input  osdvls_pkg::osdvls_state_t state_i,
  input  osdvls_pkg::osdvls_in_t    req_i,
  output osdvls_pkg::osdvls_state_t state_o,
  output osdvls_pkg::osdvls_out_t   res_o
);
  import osdvls_pkg::*;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_TEXT_ROWS - 1);

  logic [LINE_W-1:0] line_inc;
  logic [POS_W-1:0]  start;
  logic [POS_W:0]    band_end;
  logic [POS_W:0]    gfx_end;
  logic              in_text;
  logic              at_band_end;
  logic              in_gfx;

  assign line_inc    = state_i.line_count + 16'd1;
  assign start       = cfg_i.row_start[state_i.active_row];
  assign band_end    = {1'b0, start} + {3'b000, cfg_i.text_band_height};
  assign gfx_end     = {1'b0, cfg_i.graphics_start} + {1'b0, cfg_i.gfx_height};
  assign in_text     = (line_inc >= LINE_W'(start)) && (line_inc < LINE_W'(band_end));
  assign at_band_end = (line_inc == LINE_W'(band_end));
  assign in_gfx      = (line_inc >= LINE_W'(cfg_i.graphics_start))
                    && (line_inc < LINE_W'(gfx_end));

  always_comb begin
    state_o            = state_i;
    res_o.draw_kind    = KIND_NONE;
    res_o.draw_row     = '0;
    res_o.update_event = EVENT_NONE;
    if (req_i.is_hsync) begin
      if (state_i.line_count != '0) begin
        case (state_i.next_kind)
          KIND_TEXT: begin
            res_o.draw_kind = KIND_TEXT;
            res_o.draw_row  = state_i.active_row;
          end
          KIND_GRAPHICS: res_o.draw_kind = KIND_GRAPHICS;
          default:       res_o.draw_kind = KIND_NONE;
        endcase
      end
      state_o.next_kind  = KIND_NONE;
      state_o.line_count = line_inc;
      if (line_inc == LINE_W'(cfg_i.end_line)) begin
        res_o.update_event = EVENT_FRAME;
      end else if (in_text) begin
        state_o.next_kind = KIND_TEXT;
      end else if (at_band_end) begin
        res_o.update_event = EVENT_ROW;
        state_o.active_row = (state_i.active_row == ROW_LAST) ? '0
                           : state_i.active_row + 2'd1;
      end else if (in_gfx) begin
        state_o.next_kind = KIND_GRAPHICS;
      end
    end else if (state_i.line_count > VSYNC_CLEAR_ABOVE) begin
      state_o.line_count = '0;
    end
    res_o.line_number = state_o.line_count;
  end

endmodule

/* rtl/core/osd_video_line_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_video_line_scheduler_unit
// On-screen display line scheduler: turns sync pulses into draw requests.
//
// req_i carries one sync pulse per request (is_hsync high for horizontal,
// low for vertical). res_o returns exactly one result per pulse: the draw
// type and text row for the line, the line counter after the pulse and a
// frame-done or row-done event. cfg_we_i/cfg_idx_i/cfg_data_i write the
// row starts, last line, text band height and graphics window; write them
// only while no pulse is in flight.
// An accepted pulse passes the pulse register, then the result register; one
// pulse is accepted every cycle unless res_o stalls, limited by the single
// decide stage between the pulse register and the result register.
// Reset clears the line counter, the pending line type and the active row,
// and loads the default register values. When the receiver stalls, the
// result register holds and one more pulse waits in the pulse register;
// req_i.ready drops only while both are full.
// ----------------------------------------------------------------------------
module osd_video_line_scheduler_unit #(
  parameter int unsigned NUM_TEXT_ROWS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  osdvls_stream_if.sink                        req_i,
  osdvls_stream_if.source                      res_o,
  input  logic                                 cfg_we_i,
  input  logic [osdvls_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [osdvls_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import osdvls_pkg::*;

  osdvls_cfg_t   cfg_q,   cfg_d;
  osdvls_state_t state_q, state_d;
  osdvls_in_t    pulse_q;
  logic          pulse_valid_q, pulse_valid_d;
  osdvls_out_t   res_q,   res_d;
  logic          res_valid_q, res_valid_d;
  logic          req_fire;
  logic          res_load;

  logic          in_valid;
  logic          in_ready;
  logic          out_valid;
  logic          out_ready;
  osdvls_out_t   out_data;

  assign res_load   = pulse_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !pulse_valid_q || res_load;
  assign req_fire   = req_i.valid && req_i.ready;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // plain copies of the port handshakes for the checker
  assign in_valid  = req_i.valid;
  assign in_ready  = req_i.ready;
  assign out_valid = res_o.valid;
  assign out_ready = res_o.ready;
  assign out_data  = res_o.data;

  osdvls_line_decide #(
    .NUM_TEXT_ROWS (NUM_TEXT_ROWS)
  ) u_decide (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .req_i   (pulse_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_START_0:     cfg_d.row_start[0]     = cfg_data_i;
        REG_ROW_START_1:     cfg_d.row_start[1]     = cfg_data_i;
        REG_ROW_START_2:     cfg_d.row_start[2]     = cfg_data_i;
        REG_ROW_START_3:     cfg_d.row_start[3]     = cfg_data_i;
        REG_END_LINE:        cfg_d.end_line         = cfg_data_i;
        REG_TEXT_BAND:       cfg_d.text_band_height = cfg_data_i[BAND_W-1:0];
        REG_GRAPHICS_START:  cfg_d.graphics_start   = cfg_data_i;
        REG_GFX_HEIGHT:      cfg_d.gfx_height       = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    pulse_valid_d = pulse_valid_q;
    if (req_fire) begin
      pulse_valid_d = 1'b1;
    end else if (res_load) begin
      pulse_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_start[0]     <= 10'd30;
      cfg_q.row_start[1]     <= 10'd80;
      cfg_q.row_start[2]     <= 10'd130;
      cfg_q.row_start[3]     <= 10'd180;
      cfg_q.end_line         <= 10'd300;
      cfg_q.text_band_height <= 8'd18;
      cfg_q.graphics_start   <= 10'd0;
      cfg_q.gfx_height       <= 10'd0;
      state_q.line_count     <= '0;
      state_q.next_kind      <= KIND_NONE;
      state_q.active_row     <= '0;
      pulse_valid_q          <= 1'b0;
      res_valid_q            <= 1'b0;
    end else begin
      cfg_q         <= cfg_d;
      pulse_valid_q <= pulse_valid_d;
      res_valid_q   <= res_valid_d;
      if (res_load) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      pulse_q <= req_i.data;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

endmodule

/* rtl/core/osdvls_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdvls_checker
// Port-level checks for the video line scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module osdvls_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  osdvls_pkg::osdvls_out_t out_data_i
);
  import osdvls_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // a newly valid result traces back to an accepted request through the pulse and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_fire, 2))
    else $error("result without a request two cycles earlier");

  // row index only reported on text draws
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.draw_kind != KIND_TEXT) |-> out_data_i.draw_row == '0)
    else $error("draw row set on a non-text line");

  // no draw and event codes beyond the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.draw_kind != 2'd3) && (out_data_i.update_event != 2'd3))
    else $error("undefined draw or event code");

endmodule

bind osd_video_line_scheduler_unit osdvls_checker u_osdvls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid),
  .in_ready_i  (in_ready),
  .out_valid_i (out_valid),
  .out_ready_i (out_ready),
  .out_data_i  (out_data)
);

/* test/osd_video_line_scheduler_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_video_line_scheduler_check
// Watches the sync pulse channel, the line result channel and the register
// port of the line scheduler. Keeps its own copy of the line counter, the
// decided line type, the active text row and the registers, works out the
// line result of every accepted pulse and compares it field by field with
// the oldest result still owed by the block.
// ----------------------------------------------------------------------------
module osd_video_line_scheduler_check
  import osdvls_pkg::*;
#(
  parameter int unsigned NUM_TEXT_ROWS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  osdvls_stream_if              pulse_mon,
  osdvls_stream_if              line_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    lines_pending_o
);

  osdvls_cfg_t       setup;
  logic [LINE_W-1:0] line_cnt;
  logic [KIND_W-1:0] pending_kind;
  logic [ROW_W-1:0]  text_row;
  osdvls_out_t       owed_lines_q[$];
  int                fails = 0;

  task automatic schedule_line(input logic hs, output osdvls_out_t res);
    int unsigned band_start;
    int unsigned band_end;
    int unsigned window_end;
    res.draw_kind    = KIND_NONE;
    res.draw_row     = '0;
    res.update_event = EVENT_NONE;
    if (hs) begin
      if (line_cnt != '0) begin
        if (pending_kind == KIND_TEXT) begin
          res.draw_kind = KIND_TEXT;
          res.draw_row  = text_row;
        end else if (pending_kind == KIND_GRAPHICS) begin
          res.draw_kind = KIND_GRAPHICS;
        end
      end
      pending_kind = KIND_NONE;
      line_cnt     = line_cnt + 1'b1;
      // band sums are formed wide, so a band may reach past line 1023
      band_start = setup.row_start[text_row];
      band_end   = band_start + setup.text_band_height;
      window_end = setup.graphics_start + setup.gfx_height;
      if (line_cnt == setup.end_line) begin
        res.update_event = EVENT_FRAME;
      end else if (line_cnt >= band_start && line_cnt < band_end) begin
        pending_kind = KIND_TEXT;
      end else if (line_cnt == band_end) begin
        res.update_event = EVENT_ROW;
        text_row = ROW_W'((text_row + 1) % NUM_TEXT_ROWS);
      end else if (line_cnt >= setup.graphics_start && line_cnt < window_end) begin
        pending_kind = KIND_GRAPHICS;
      end
    end else if (line_cnt > VSYNC_CLEAR_ABOVE) begin
      line_cnt = '0;
    end
    res.line_number = line_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    osdvls_out_t want;
    osdvls_out_t got;
    if (!rst_ni) begin
      setup.row_start[0]     = 10'd30;
      setup.row_start[1]     = 10'd80;
      setup.row_start[2]     = 10'd130;
      setup.row_start[3]     = 10'd180;
      setup.end_line         = 10'd300;
      setup.text_band_height = 8'd18;
      setup.graphics_start   = 10'd0;
      setup.gfx_height       = 10'd0;
      line_cnt     = '0;
      pending_kind = KIND_NONE;
      text_row     = '0;
      owed_lines_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROW_START_0:     setup.row_start[0]     = cfg_data_i;
          REG_ROW_START_1:     setup.row_start[1]     = cfg_data_i;
          REG_ROW_START_2:     setup.row_start[2]     = cfg_data_i;
          REG_ROW_START_3:     setup.row_start[3]     = cfg_data_i;
          REG_END_LINE:        setup.end_line         = cfg_data_i;
          REG_TEXT_BAND:       setup.text_band_height = cfg_data_i[BAND_W-1:0];
          REG_GRAPHICS_START:  setup.graphics_start   = cfg_data_i;
          REG_GFX_HEIGHT:      setup.gfx_height       = cfg_data_i;
          default: ;
        endcase
      end
      if (line_mon.valid && line_mon.ready) begin
        got = line_mon.data;
        if (owed_lines_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: line result with no pulse owed: kind %0d row %0d line %0d event %0d",
                     $time, got.draw_kind, got.draw_row, got.line_number, got.update_event);
          end
        end else begin
          want = owed_lines_q.pop_front();
          if (got.draw_kind !== want.draw_kind || got.draw_row !== want.draw_row ||
              got.line_number !== want.line_number ||
              got.update_event !== want.update_event) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: line result differs: expected kind %0d row %0d line %0d event %0d",
                       $time, want.draw_kind, want.draw_row, want.line_number,
                       want.update_event);
              $display("%0t:                      actual   kind %0d row %0d line %0d event %0d",
                       $time, got.draw_kind, got.draw_row, got.line_number, got.update_event);
            end
          end
        end
      end
      if (pulse_mon.valid && pulse_mon.ready) begin
        schedule_line(pulse_mon.data.is_hsync, want);
        owed_lines_q.push_back(want);
      end
    end
    fail_count_o    <= fails;
    lines_pending_o <= owed_lines_q.size();
  end

endmodule

/* test/osd_video_line_scheduler_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_video_line_scheduler_unit_test
// Drives sync pulses and register settings into the line scheduler: a short
// directed sequence through row changes and frame done, extreme register
// settings, randomly set up frames with stray vertical pulses, and a final
// frame without stalls. Both channels stall at random; the checker beside
// the block predicts and compares every line result.
// ----------------------------------------------------------------------------
module osd_video_line_scheduler_unit_test;
  import osdvls_pkg::*;

  localparam int unsigned TEXT_ROWS     = 4;
  localparam int unsigned RANDOM_PULSES = 280;
  localparam int unsigned CALM_PULSES   = 40;
  localparam int unsigned STALL_LIMIT   = 1000;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    lines_pending;
  bit                    calm = 1'b0;
  int unsigned           quiet_cycles = 0;
  int unsigned           random_pulses = 0;

  osdvls_stream_if #(.T(osdvls_in_t))  pulse_if ();
  osdvls_stream_if #(.T(osdvls_out_t)) line_if ();

  always #5 clk_i = ~clk_i;

  osd_video_line_scheduler_unit #(
    .NUM_TEXT_ROWS(TEXT_ROWS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (pulse_if),
    .res_o     (line_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  osd_video_line_scheduler_check #(
    .NUM_TEXT_ROWS(TEXT_ROWS)
  ) line_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pulse_mon      (pulse_if),
    .line_mon       (line_if),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .lines_pending_o(lines_pending)
  );

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic load_setup(input osdvls_cfg_t s);
    put_reg(REG_ROW_START_0, s.row_start[0]);
    put_reg(REG_ROW_START_1, s.row_start[1]);
    put_reg(REG_ROW_START_2, s.row_start[2]);
    put_reg(REG_ROW_START_3, s.row_start[3]);
    put_reg(REG_END_LINE, s.end_line);
    // upper data bits are junk for the 8-bit band register
    put_reg(REG_TEXT_BAND, {2'($urandom_range(0, 3)), s.text_band_height});
    put_reg(REG_GRAPHICS_START, s.graphics_start);
    put_reg(REG_GFX_HEIGHT, s.gfx_height);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    pulse_if.valid <= 1'b0;
    @(posedge clk_i);
    while (lines_pending != 0) @(posedge clk_i);
  endtask

  task automatic reconfigure(input osdvls_cfg_t s);
    settle();
    repeat (3) @(posedge clk_i);
    load_setup(s);
  endtask

  task automatic send_pulse(input logic hs);
    if (!calm && $urandom_range(0, 7) == 0) begin
      pulse_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    pulse_if.valid         <= 1'b1;
    pulse_if.data.is_hsync <= hs;
    do @(posedge clk_i); while (!pulse_if.ready);
  endtask

  // vertical pulse, then a run of horizontal ones with stray vertical pulses
  task automatic run_frame(input int unsigned hsyncs, input int unsigned stray_pct);
    send_pulse(1'b0);
    for (int unsigned i = 0; i < hsyncs; i++) begin
      send_pulse($urandom_range(0, 99) < stray_pct ? 1'b0 : 1'b1);
      if (!calm && $urandom_range(0, 199) == 0) settle();
    end
    random_pulses += hsyncs + 1;
  endtask

  function automatic osdvls_cfg_t random_setup();
    osdvls_cfg_t s;
    int unsigned pos;
    if ($urandom_range(0, 4) == 0) begin
      for (int r = 0; r < ROW_SLOTS; r++) s.row_start[r] = POS_W'($urandom_range(0, 1023));
      s.end_line         = POS_W'($urandom_range(1, 1023));
      s.text_band_height = BAND_W'($urandom_range(1, 255));
      s.graphics_start   = POS_W'($urandom_range(0, 1023));
      s.gfx_height       = POS_W'($urandom_range(0, 1023));
    end else begin
      // rows in order down the screen, so every row gets its turn
      s.text_band_height = BAND_W'($urandom_range(1, 40));
      pos = $urandom_range(0, 40);
      for (int r = 0; r < ROW_SLOTS; r++) begin
        s.row_start[r] = POS_W'(pos);
        pos += s.text_band_height + $urandom_range(1, 30);
      end
      s.end_line       = POS_W'($urandom_range(150, 260));
      s.graphics_start = POS_W'($urandom_range(0, 300));
      s.gfx_height     = ($urandom_range(0, 4) == 0) ? '0 : POS_W'($urandom_range(1, 300));
    end
    return s;
  endfunction

  function automatic int unsigned frame_len(input osdvls_cfg_t s);
    if ($urandom_range(0, 6) == 0) return $urandom_range(1, 200);
    return ((s.end_line > 200) ? s.end_line : 201) + $urandom_range(0, 20);
  endfunction

  initial begin
    line_if.ready <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        line_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        line_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pulse_if.valid && pulse_if.ready) || (line_if.valid && line_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    osdvls_cfg_t s;
    int unsigned len;
    pulse_if.valid <= 1'b0;
    pulse_if.data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values, counter at zero
    send_pulse(1'b0);
    send_pulse(1'b1);
    send_pulse(1'b0);

    // one-line rows: text, row done through all four rows, frame done, graphics
    s.row_start[0]     = 10'd1;
    s.row_start[1]     = 10'd3;
    s.row_start[2]     = 10'd5;
    s.row_start[3]     = 10'd7;
    s.end_line         = 10'd10;
    s.text_band_height = 8'd1;
    s.graphics_start   = 10'd0;
    s.gfx_height       = 10'd12;
    reconfigure(s);
    repeat (14) send_pulse(1'b1);
    send_pulse(1'b0);

    // extremes: frame done at line 1, widest band
    s.row_start[0]     = 10'd0;
    s.row_start[1]     = 10'd1023;
    s.row_start[2]     = 10'd0;
    s.row_start[3]     = 10'd1023;
    s.end_line         = 10'd1;
    s.text_band_height = 8'd255;
    s.graphics_start   = 10'd1023;
    s.gfx_height       = 10'd1023;
    reconfigure(s);
    run_frame(300, 0);

    // every line graphics, vertical clear while a draw is decided
    s.row_start        = {4{10'd1023}};
    s.end_line         = 10'd1023;
    s.text_band_height = 8'd1;
    s.graphics_start   = 10'd0;
    s.gfx_height       = 10'd1023;
    reconfigure(s);
    run_frame(210, 0);

    random_pulses = 0;
    while (random_pulses < RANDOM_PULSES) begin
      s = random_setup();
      reconfigure(s);
      repeat (2) begin
        if (random_pulses < RANDOM_PULSES) begin
          len = frame_len(s);
          if (len > RANDOM_PULSES - random_pulses) len = RANDOM_PULSES - random_pulses;
          run_frame(len, ($urandom_range(0, 3) == 0) ? 2 : 0);
        end
      end
    end

    // closing frame with no stalls: text rows, graphics and frame done
    s.row_start[0]     = 10'd2;
    s.row_start[1]     = 10'd10;
    s.row_start[2]     = 10'd18;
    s.row_start[3]     = 10'd26;
    s.end_line         = 10'd35;
    s.text_band_height = 8'd4;
    s.graphics_start   = 10'd0;
    s.gfx_height       = 10'd40;
    reconfigure(s);
    calm = 1'b1;
    run_frame(CALM_PULSES, 0);
    send_pulse(1'b0);

    settle();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
